@@ design/complex_upsampler_interp_defines.svh @@
// Assertion macros for the complex upsampler.
`ifndef COMPLEX_UPSAMPLER_INTERP_DEFINES_SVH
`define COMPLEX_UPSAMPLER_INTERP_DEFINES_SVH

`ifndef SYNTH
`define CUI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("complex_upsampler_interp: check failed");
`define CUI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("complex_upsampler_interp: reset check failed");
`else
`define CUI_ASSERT(label, clk, rstn, prop)
`define CUI_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ design/cui_pkg.sv @@
package cui_pkg;

    localparam int MAX_FACTOR   = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int CFG_FACTOR_W = 7;
    localparam int CFG_MODE_W   = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam int FACT_W = $clog2(MAX_FACTOR + 1);
    localparam int CMP_W  = (FACT_W > CFG_FACTOR_W) ? FACT_W : CFG_FACTOR_W;
    localparam int CNT_W  = $clog2(MAX_FACTOR);
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int REM_W  = FACT_W + 1;

    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES     = (DIFF_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_PAD_W      = DIV_CYCLES * DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = CFG_INDEX_W'(1);

    localparam logic [CFG_MODE_W-1:0] MODE_ZERO   = CFG_MODE_W'(0);
    localparam logic [CFG_MODE_W-1:0] MODE_HOLD   = CFG_MODE_W'(1);
    localparam logic [CFG_MODE_W-1:0] MODE_LINEAR = CFG_MODE_W'(2);

    localparam logic [CFG_FACTOR_W-1:0] FACTOR_RESET = CFG_FACTOR_W'(5);
    localparam logic [CFG_MODE_W-1:0]   MODE_RESET   = MODE_HOLD;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_HOLD,
        KIND_LINEAR
    } kind_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } fr_state_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] in_i;
        logic signed [SAMPLE_WIDTH-1:0] in_q;
    } cui_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_i;
        logic signed [SAMPLE_WIDTH-1:0] out_q;
        logic                           last;
    } cui_out_t;

    typedef struct packed {
        logic [CFG_FACTOR_W-1:0] factor;
        logic [CFG_MODE_W-1:0]   mode;
    } cui_cfg_t;

    typedef struct packed {
        kind_t                   kind;
        logic [FACT_W-1:0]       factor;
        logic [SAMPLE_WIDTH-1:0] cur_i;
        logic [SAMPLE_WIDTH-1:0] cur_q;
        logic [SAMPLE_WIDTH-1:0] prev_i;
        logic [SAMPLE_WIDTH-1:0] prev_q;
        logic [DIFF_W-1:0]       q_i;
        logic [DIFF_W-1:0]       q_q;
        logic [FACT_W-1:0]       r_i;
        logic [FACT_W-1:0]       r_q;
    } cui_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cui_qstat_t;

    // one restoring division step: returns {new remainder, quotient bit}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [FACT_W-1:0] divisor);
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] dvs;
        shifted = {rem[REM_W-2:0], bit_in};
        dvs     = {1'b0, divisor};
        if (shifted >= dvs) begin
            return {shifted - dvs, 1'b1};
        end
        return {shifted, 1'b0};
    endfunction

endpackage

@@ design/cui_queue.sv @@
module cui_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  cui_pkg::cui_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output cui_pkg::cui_entry_t pop_entry,
    output cui_pkg::cui_qstat_t stat
);
    import cui_pkg::*;

    cui_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign stat.full  = !push_ready;
    assign stat.empty = !pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/cui_front.sv @@
module cui_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  cui_pkg::cui_cfg_t   cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  cui_pkg::cui_in_t    s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output cui_pkg::cui_entry_t push_entry
);
    import cui_pkg::*;

    fr_state_t               state_reg;
    fr_state_t               state_next;
    logic [SAMPLE_WIDTH-1:0] prev_i_reg;
    logic [SAMPLE_WIDTH-1:0] prev_q_reg;
    kind_t                   kind_reg;
    logic [FACT_W-1:0]       factor_reg;
    logic [SAMPLE_WIDTH-1:0] cur_i_reg;
    logic [SAMPLE_WIDTH-1:0] cur_q_reg;
    logic [SAMPLE_WIDTH-1:0] old_i_reg;
    logic [SAMPLE_WIDTH-1:0] old_q_reg;
    logic                    neg_i_reg;
    logic                    neg_q_reg;
    logic [DIV_PAD_W-1:0]    num_i_reg;
    logic [DIV_PAD_W-1:0]    num_q_reg;
    logic [REM_W-1:0]        rem_i_reg;
    logic [REM_W-1:0]        rem_q_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;

    logic [CMP_W-1:0]        fcmp;
    logic [FACT_W-1:0]       f_eff;
    kind_t                   kind_in;
    logic [DIFF_W-1:0]       d_i;
    logic [DIFF_W-1:0]       d_q;
    logic [DIFF_W-1:0]       mag_i;
    logic [DIFF_W-1:0]       mag_q;
    logic [DIV_PAD_W-1:0]    num_i_step;
    logic [DIV_PAD_W-1:0]    num_q_step;
    logic [REM_W-1:0]        rem_i_step;
    logic [REM_W-1:0]        rem_q_step;
    logic [DIFF_W-1:0]       qa_i;
    logic [DIFF_W-1:0]       qa_q;
    logic [FACT_W-1:0]       ra_i;
    logic [FACT_W-1:0]       ra_q;
    logic                    accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        fcmp = CMP_W'(cfg.factor);
        if (fcmp == '0) begin
            f_eff = FACT_W'(1);
        end else if (fcmp > CMP_W'(MAX_FACTOR)) begin
            f_eff = FACT_W'(MAX_FACTOR);
        end else begin
            f_eff = FACT_W'(fcmp);
        end
    end

    always_comb begin
        if (cfg.mode == MODE_ZERO) begin
            kind_in = KIND_ZERO;
        end else if (cfg.mode == MODE_LINEAR && f_eff != FACT_W'(1)) begin
            kind_in = KIND_LINEAR;
        end else begin
            kind_in = KIND_HOLD;
        end
    end

    assign d_i   = {s_data.in_i[SAMPLE_WIDTH-1], s_data.in_i}
                 - {prev_i_reg[SAMPLE_WIDTH-1], prev_i_reg};
    assign d_q   = {s_data.in_q[SAMPLE_WIDTH-1], s_data.in_q}
                 - {prev_q_reg[SAMPLE_WIDTH-1], prev_q_reg};
    assign mag_i = d_i[DIFF_W-1] ? (~d_i + DIFF_W'(1)) : d_i;
    assign mag_q = d_q[DIFF_W-1] ? (~d_q + DIFF_W'(1)) : d_q;

    always_comb begin
        logic [DIV_PAD_W-1:0] ni;
        logic [DIV_PAD_W-1:0] nq;
        logic [REM_W-1:0]     ri;
        logic [REM_W-1:0]     rq;
        logic [REM_W:0]       si;
        logic [REM_W:0]       sq;
        ni = num_i_reg;
        nq = num_q_reg;
        ri = rem_i_reg;
        rq = rem_q_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            si = div_step(ri, ni[DIV_PAD_W-1], factor_reg);
            sq = div_step(rq, nq[DIV_PAD_W-1], factor_reg);
            ri = si[REM_W:1];
            rq = sq[REM_W:1];
            ni = {ni[DIV_PAD_W-2:0], si[0]};
            nq = {nq[DIV_PAD_W-2:0], sq[0]};
        end
        num_i_step = ni;
        num_q_step = nq;
        rem_i_step = ri;
        rem_q_step = rq;
    end

    // turn the magnitude quotient into a floor quotient and non-negative remainder
    assign qa_i = num_i_reg[DIFF_W-1:0];
    assign qa_q = num_q_reg[DIFF_W-1:0];
    assign ra_i = rem_i_reg[FACT_W-1:0];
    assign ra_q = rem_q_reg[FACT_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (s_valid) begin
                    state_next = (kind_in == KIND_LINEAR) ? FR_DIV : FR_PUSH;
                end
            end
            FR_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (push_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == FR_IDLE);
        push_valid        = (state_reg == FR_PUSH);
        push_entry.kind   = kind_reg;
        push_entry.factor = factor_reg;
        push_entry.cur_i  = cur_i_reg;
        push_entry.cur_q  = cur_q_reg;
        push_entry.prev_i = old_i_reg;
        push_entry.prev_q = old_q_reg;
        if (neg_i_reg) begin
            push_entry.q_i = (ra_i != '0) ? ~qa_i : (~qa_i + DIFF_W'(1));
            push_entry.r_i = (ra_i != '0) ? (factor_reg - ra_i) : ra_i;
        end else begin
            push_entry.q_i = qa_i;
            push_entry.r_i = ra_i;
        end
        if (neg_q_reg) begin
            push_entry.q_q = (ra_q != '0) ? ~qa_q : (~qa_q + DIFF_W'(1));
            push_entry.r_q = (ra_q != '0) ? (factor_reg - ra_q) : ra_q;
        end else begin
            push_entry.q_q = qa_q;
            push_entry.r_q = ra_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FR_IDLE;
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                prev_i_reg <= s_data.in_i;
                prev_q_reg <= s_data.in_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= kind_in;
            factor_reg <= f_eff;
            cur_i_reg  <= s_data.in_i;
            cur_q_reg  <= s_data.in_q;
            old_i_reg  <= prev_i_reg;
            old_q_reg  <= prev_q_reg;
            neg_i_reg  <= d_i[DIFF_W-1];
            neg_q_reg  <= d_q[DIFF_W-1];
            num_i_reg  <= DIV_PAD_W'(mag_i);
            num_q_reg  <= DIV_PAD_W'(mag_q);
            rem_i_reg  <= '0;
            rem_q_reg  <= '0;
            cnt_reg    <= DIV_CNT_W'(DIV_CYCLES - 1);
        end else if (state_reg == FR_DIV) begin
            num_i_reg <= num_i_step;
            num_q_reg <= num_q_step;
            rem_i_reg <= rem_i_step;
            rem_q_reg <= rem_q_step;
            cnt_reg   <= cnt_reg - DIV_CNT_W'(1);
        end
    end

endmodule

@@ design/cui_back.sv @@
module cui_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cui_pkg::cui_entry_t pop_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output cui_pkg::cui_out_t   m_data
);
    import cui_pkg::*;

    logic              active_reg;
    cui_entry_t        ent_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIFF_W-1:0] acc_i_reg;
    logic [DIFF_W-1:0] acc_q_reg;
    logic [FACT_W-1:0] racc_i_reg;
    logic [FACT_W-1:0] racc_q_reg;
    logic              m_valid_reg;
    cui_out_t          m_data_reg;

    logic              emit;
    logic              is_last;
    logic              do_pop;
    cui_out_t          result;
    logic [DIFF_W-1:0] lin_i;
    logic [DIFF_W-1:0] lin_q;
    logic [REM_W-1:0]  rsum_i;
    logic [REM_W-1:0]  rsum_q;
    logic              wrap_i;
    logic              wrap_q;
    logic [DIFF_W-1:0] acc_i_next;
    logic [DIFF_W-1:0] acc_q_next;
    logic [FACT_W-1:0] racc_i_next;
    logic [FACT_W-1:0] racc_q_next;

    assign emit      = active_reg && (!m_valid_reg || m_ready);
    assign is_last   = (FACT_W'(cnt_reg) == ent_reg.factor - FACT_W'(1));
    assign pop_ready = !active_reg || (emit && is_last);
    assign do_pop    = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign lin_i = {ent_reg.prev_i[SAMPLE_WIDTH-1], ent_reg.prev_i} + acc_i_reg;
    assign lin_q = {ent_reg.prev_q[SAMPLE_WIDTH-1], ent_reg.prev_q} + acc_q_reg;

    always_comb begin
        result.last = is_last;
        unique case (ent_reg.kind)
            KIND_ZERO: begin
                result.out_i = (cnt_reg == '0) ? ent_reg.cur_i : '0;
                result.out_q = (cnt_reg == '0) ? ent_reg.cur_q : '0;
            end
            KIND_LINEAR: begin
                result.out_i = lin_i[SAMPLE_WIDTH-1:0];
                result.out_q = lin_q[SAMPLE_WIDTH-1:0];
            end
            default: begin
                result.out_i = ent_reg.cur_i;
                result.out_q = ent_reg.cur_q;
            end
        endcase
    end

    always_comb begin
        rsum_i      = {1'b0, racc_i_reg} + {1'b0, ent_reg.r_i};
        rsum_q      = {1'b0, racc_q_reg} + {1'b0, ent_reg.r_q};
        wrap_i      = (rsum_i >= {1'b0, ent_reg.factor});
        wrap_q      = (rsum_q >= {1'b0, ent_reg.factor});
        racc_i_next = wrap_i ? FACT_W'(rsum_i - {1'b0, ent_reg.factor}) : FACT_W'(rsum_i);
        racc_q_next = wrap_q ? FACT_W'(rsum_q - {1'b0, ent_reg.factor}) : FACT_W'(rsum_q);
        acc_i_next  = acc_i_reg + ent_reg.q_i + DIFF_W'(wrap_i);
        acc_q_next  = acc_q_reg + ent_reg.q_q + DIFF_W'(wrap_q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_pop) begin
                active_reg <= 1'b1;
            end else if (emit && is_last) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= result;
        end
        if (do_pop) begin
            ent_reg    <= pop_entry;
            cnt_reg    <= '0;
            acc_i_reg  <= '0;
            acc_q_reg  <= '0;
            racc_i_reg <= '0;
            racc_q_reg <= '0;
        end else if (emit) begin
            cnt_reg    <= cnt_reg + CNT_W'(1);
            acc_i_reg  <= acc_i_next;
            acc_q_reg  <= acc_q_next;
            racc_i_reg <= racc_i_next;
            racc_q_reg <= racc_q_next;
        end
    end

endmodule

@@ design/complex_upsampler_interp.sv @@
// Complex integer-factor upsampler, Q1.15 I/Q.
// s_valid/s_ready/s_data take one input word; m_valid/m_ready/m_data give a run
// of factor words per input, one per cycle unless stalled, with last on the final one.
// cfg_valid/cfg_ready/cfg_index/cfg_data write factor (index 0) and mode (index 1);
// cfg_ready is always high. Write configuration only while the block is idle.
// A front section takes one input at a time and takes the next only once the
// previous one has been pushed; zero and hold inputs go straight to the queue,
// while in linear mode a 4-bit-per-cycle divider first forms the step
// (cur - prev) / factor. A two-entry queue hands the work to the back section,
// which emits one result per cycle unless stalled, from an incremental
// quotient/remainder accumulator.
// When m_ready is low the result register holds and the back section stalls;
// the queue fills, then the front stops taking inputs.
// Reset (aresetn low, synchronous) clears the previous sample to zero, sets
// factor 5 and hold mode, and empties the queue and the output register.
`include "complex_upsampler_interp_defines.svh"

module complex_upsampler_interp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cui_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cui_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cui_pkg::cui_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cui_pkg::cui_out_t                   m_data
);
    import cui_pkg::*;

    logic [CFG_FACTOR_W-1:0] factor_reg;
    logic [CFG_MODE_W-1:0]   mode_reg;
    cui_cfg_t                cfg;
    logic                    push_valid;
    logic                    push_ready;
    cui_entry_t              push_entry;
    logic                    pop_valid;
    logic                    pop_ready;
    cui_entry_t              pop_entry;
    cui_qstat_t              qstat;

    assign cfg_ready  = 1'b1;
    assign cfg.factor = factor_reg;
    assign cfg.mode   = mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
            mode_reg   <= MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FACTOR) begin
                factor_reg <= cfg_data[CFG_FACTOR_W-1:0];
            end else if (cfg_index == CFG_MODE) begin
                mode_reg <= cfg_data[CFG_MODE_W-1:0];
            end
        end
    end

    cui_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    cui_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .stat       (qstat)
    );

    cui_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `CUI_ASSERT(a_one_word_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `CUI_ASSERT(a_queue_status, aclk, aresetn, !(qstat.full && qstat.empty))
    `CUI_ASSERT(a_push_wait, aclk, aresetn, push_valid && !push_ready |=> push_valid)
    `CUI_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid && s_ready)

endmodule

@@ tb/sv/tb_complex_upsampler_interp.sv @@
module tb_complex_upsampler_interp;
    import cui_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_WORDS    = 250;
    localparam int MAX_REPORTS     = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);
    localparam logic [CFG_MODE_W-1:0]  MODE_ALIAS  = CFG_MODE_W'(3);

    class upsample_scoreboard;
        logic [CFG_FACTOR_W-1:0] factor_reg;
        logic [CFG_MODE_W-1:0]   mode_reg;
        int                      prior_i;
        int                      prior_q;
        cui_out_t                run_q[$];
        int                      errors;

        function new();
            factor_reg = FACTOR_RESET;
            mode_reg   = MODE_RESET;
            prior_i    = 0;
            prior_q    = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FACTOR: factor_reg = val[CFG_FACTOR_W-1:0];
                CFG_MODE:   mode_reg   = val[CFG_MODE_W-1:0];
                default: ;
            endcase
        endfunction

        function int ramp(int a, int b, int j, int f);
            int n;
            int q;
            n = j * (b - a);
            q = n / f;
            if ((n % f) != 0 && n < 0) begin
                q = q - 1;
            end
            return a + q;
        endfunction

        function void note_sample(cui_in_t d);
            int       ci;
            int       cq;
            int       f;
            int       oi;
            int       oq;
            cui_out_t w;
            ci = $signed(d.in_i);
            cq = $signed(d.in_q);
            f  = factor_reg;
            if (f < 1) begin
                f = 1;
            end
            if (f > MAX_FACTOR) begin
                f = MAX_FACTOR;
            end
            for (int j = 0; j < f; j++) begin
                if (mode_reg == MODE_ZERO) begin
                    oi = (j == 0) ? ci : 0;
                    oq = (j == 0) ? cq : 0;
                end else if (mode_reg == MODE_LINEAR && f > 1) begin
                    oi = ramp(prior_i, ci, j, f);
                    oq = ramp(prior_q, cq, j, f);
                end else begin
                    oi = ci;
                    oq = cq;
                end
                w.out_i = SAMPLE_WIDTH'(oi);
                w.out_q = SAMPLE_WIDTH'(oq);
                w.last  = (j == f - 1);
                run_q = {run_q, w};
            end
            prior_i = ci;
            prior_q = cq;
        endfunction

        function void check_word(cui_out_t got);
            cui_out_t exp_w;
            if (run_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected word: i=%0d q=%0d last=%0b",
                             got.out_i, got.out_q, got.last);
                end
            end else begin
                exp_w = run_q.pop_front();
                if (got.out_i !== exp_w.out_i || got.out_q !== exp_w.out_q ||
                    got.last !== exp_w.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                                 exp_w.out_i, exp_w.out_q, exp_w.last,
                                 got.out_i, got.out_q, got.last);
                    end
                end
            end
        endfunction

        function int pending();
            return run_q.size();
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    cui_in_t                 s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    cui_out_t                m_data;

    logic                    quiet     = 1'b0;
    logic                    hold_req  = 1'b0;
    int                      hold_left = 0;
    int                      idle_cycles = 0;
    int                      sent_random = 0;

    upsample_scoreboard sb = new();

    complex_upsampler_interp DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] fdata,
                             input logic [CFG_DATA_W-1:0] mdata);
        drain();
        write_reg(CFG_FACTOR, fdata);
        write_reg(CFG_MODE, mdata);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input cui_in_t d);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(d);
    endtask

    task automatic send_pair(input int vi, input int vq);
        cui_in_t d;
        d.in_i = SAMPLE_WIDTH'(vi);
        d.in_q = SAMPLE_WIDTH'(vq);
        send_word(d);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return SAMPLE_WIDTH'(-32768);
            1: return SAMPLE_WIDTH'(32767);
            2: return '0;
            3: return '1;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] fdata,
                             input logic [CFG_DATA_W-1:0] mdata,
                             input int count, input int hold_at);
        cui_in_t d;
        configure(fdata, mdata);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_req = 1'b1;
            end
            d.in_i = pick_value();
            d.in_q = pick_value();
            send_word(d);
            sent_random++;
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] fdata;
        int                    r;
        int                    count;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_pair(32767, -32768);
        send_pair(0, -1);

        configure(8'd1, {6'h00, MODE_ZERO});
        send_pair(-32768, 32767);
        send_pair(32767, -32768);

        configure(8'd1, {6'h3F, MODE_LINEAR});
        send_pair(12345, -12345);

        drain();
        write_reg(CFG_SPARE_A, 8'h55);
        write_reg(CFG_SPARE_B, 8'hAA);
        cfg_valid <= 1'b0;

        configure(8'h80, {6'h00, MODE_ALIAS});
        send_pair(-20000, 20000);

        configure(8'd64, {6'h00, MODE_LINEAR});
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(32767, -32768);

        configure(8'hFF, {6'h3F, MODE_ZERO});
        send_pair(-1, -1);
        send_pair(1, 1);

        configure(8'd65, {6'h00, MODE_HOLD});
        send_pair(-32768, -32768);

        configure(8'd3, {6'h00, MODE_LINEAR});
        send_pair(0, 0);
        send_pair(-1, 1);
        send_pair(1, -1);
        send_pair(-32768, 32767);
        send_pair(5, -5);
        send_pair(-5, 5);

        configure(8'hFE, {6'h3F, MODE_LINEAR});
        send_pair(100, -100);
        send_pair(-100, 100);
        send_pair(0, 0);

        // stall the result side long enough to back up the input
        run_phase(8'd2, CFG_DATA_W'($urandom_range(0, 255)), 40, 5);

        quiet = 1'b1;
        run_phase(8'd4, {6'h00, MODE_LINEAR}, 30, -1);
        quiet = 1'b0;

        while (sent_random < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                fdata = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 9))};
            end else if (r < 92) begin
                fdata = CFG_DATA_W'($urandom_range(10, 40));
            end else begin
                fdata = CFG_DATA_W'($urandom);
            end
            count = (fdata[CFG_FACTOR_W-1:0] > 32) ? $urandom_range(1, 3)
                                                   : $urandom_range(5, 25);
            run_phase(fdata, CFG_DATA_W'($urandom_range(0, 255)), count, -1);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/cui_pkg.sv
design/cui_queue.sv
design/cui_front.sv
design/cui_back.sv
design/complex_upsampler_interp.sv
tb/sv/tb_complex_upsampler_interp.sv
